// ===== hw/rtl/pt32_pkg.sv =====
package pt32_pkg;

  localparam int unsigned NumW     = 32;
  localparam int unsigned DivW     = 17;
  localparam int unsigned SqW      = 34;
  localparam int unsigned RemBits  = 4;
  localparam int unsigned RemSteps = NumW / RemBits;
  localparam int unsigned RemCntW  = $clog2(RemSteps);

  localparam logic [NumW-1:0] FirstDiv   = 32'd3;
  localparam logic [SqW-1:0]  FirstSq    = 34'd9;
  localparam logic [NumW-1:0] SmallLimit = 32'd3;
  localparam logic [NumW-1:0] EvenPrime  = 32'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
  } rem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

// ===== hw/rtl/pt32_rem_unit.sv =====
module pt32_rem_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pt32_pkg::rem_req_t           req_i,
  input  logic [pt32_pkg::NumW-1:0]    dividend_i,
  input  logic [pt32_pkg::DivW-1:0]    divisor_i,
  output pt32_pkg::rem_rsp_t           rsp_o
);
  import pt32_pkg::*;

  logic               busy_q, busy_d;
  logic [RemCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    rem_q, rem_d;
  logic [NumW-1:0]    shf_q, shf_d;
  logic [DivW:0]      trial;
  logic [DivW-1:0]    part;
  logic               last;

  assign last = busy_q && (cnt_q == RemCntW'(RemSteps - 1));

  // restoring remainder, RemBits quotient bits per cycle
  always_comb begin
    part = rem_q;
    for (int i = 0; i < RemBits; i++) begin
      trial = {part, shf_q[NumW-1-i]};
      if (trial >= {1'b0, divisor_i}) begin
        trial = trial - {1'b0, divisor_i};
      end
      part = trial[DivW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    shf_d  = shf_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      shf_d  = dividend_i;
    end else if (busy_q) begin
      cnt_d  = cnt_q + RemCntW'(1);
      rem_d  = part;
      shf_d  = shf_q << RemBits;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = last;
  assign rsp_o.zero = (part == '0);

endmodule

// ===== hw/rtl/pt32_seq.sv =====
module pt32_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [pt32_pkg::NumW-1:0]    candidate_i,
  output logic                         in_stall_o,
  output logic                         res_valid_o,
  output logic                         res_o,
  input  logic                         res_take_i,
  output pt32_pkg::rem_req_t           rem_req_o,
  input  pt32_pkg::rem_rsp_t           rem_rsp_i,
  output logic [pt32_pkg::NumW-1:0]    dividend_o,
  output logic [pt32_pkg::DivW-1:0]    divisor_o
);
  import pt32_pkg::*;

  state_e          state_q, state_d;
  logic [NumW-1:0] n_q, n_d;
  logic [DivW-1:0] d_q, d_d;
  logic [SqW-1:0]  sq_q, sq_d;
  logic            step4_q, step4_d;
  logic            res_q, res_d;

  always_comb begin
    state_d         = state_q;
    n_d             = n_q;
    d_d             = d_q;
    sq_d            = sq_q;
    step4_d         = step4_q;
    res_d           = res_q;
    in_stall_o      = 1'b1;
    res_valid_o     = 1'b0;
    rem_req_o.start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          n_d     = candidate_i;
          d_d     = DivW'(FirstDiv);
          sq_d    = FirstSq;
          step4_d = 1'b0;
          if (candidate_i < SmallLimit || !candidate_i[0]) begin
            res_d   = (candidate_i == EvenPrime);
            state_d = ST_DONE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_q > SqW'(n_q)) begin
          res_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          rem_req_o.start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_rsp_i.done) begin
          if (rem_rsp_i.zero) begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end else begin
            // skip multiples of 2 and 3: steps of 2 and 4 alternate after 5
            if (step4_q) begin
              d_d  = d_q + DivW'(4);
              sq_d = sq_q + (SqW'(d_q) << 3) + SqW'(16);
            end else begin
              d_d  = d_q + DivW'(2);
              sq_d = sq_q + (SqW'(d_q) << 2) + SqW'(4);
            end
            step4_d = (d_q == DivW'(FirstDiv)) ? 1'b0 : !step4_q;
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
    step4_q <= step4_d;
    res_q   <= res_d;
  end

  assign res_o      = res_q;
  assign dividend_o = n_q;
  assign divisor_o  = d_q;

endmodule

// ===== hw/rtl/prime_test_32bit_top.sv =====
// Primality test for a 32-bit unsigned word. Zero, one and even words are decided
// without trial division (only 2 is prime). An odd word is trial-divided by 3 and then by
// every number of the form 6k+-1 whose square does not exceed it; a single remainder
// unit retires 4 bits a cycle, and each trial divisor takes one bound check followed
// by the remainder steps. A composite word stops at its smallest factor; a prime
// near 2^32 needs about 21850 divisors. One word is in work at a time and the input
// is stalled until its result has moved into the output register; that register
// holds the result while the next word is taken.
module prime_test_32bit_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] candidate_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_prime_o
);
  import pt32_pkg::*;

  rem_req_t        rem_req;
  rem_rsp_t        rem_rsp;
  logic [NumW-1:0] dividend;
  logic [DivW-1:0] divisor;
  logic            res_valid;
  logic            res;
  logic            res_take;
  logic            out_valid_q;
  logic            is_prime_q;

  assign res_take = !out_valid_q || !out_stall_i;

  pt32_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .candidate_i (candidate_i),
    .in_stall_o  (in_stall_o),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take),
    .rem_req_o   (rem_req),
    .rem_rsp_i   (rem_rsp),
    .dividend_o  (dividend),
    .divisor_o   (divisor)
  );

  pt32_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (rem_req),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .rsp_o      (rem_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      is_prime_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

endmodule

// ===== hw/rtl/pt32_checker.sv =====
module pt32_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] candidate_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        is_prime_o
);

  // held result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_prime_o))
    else $error("result word changed while stalled");

  // one word in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a word is in work");

  // even words resolve at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !candidate_i[0] && !out_valid_o |->
      ##2 out_valid_o && (is_prime_o == ($past(candidate_i, 2) == 32'd2)))
    else $error("wrong or late result for even word");

  // no result without a word in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without accepted word");

endmodule

bind prime_test_32bit_top pt32_checker u_chk (.*);

// ===== tb/sv/prime_test_32bit_top_tb.sv =====
`timescale 1ns / 1ps

module prime_test_32bit_top_tb;

  localparam int unsigned MarkDepth  = 32768;
  localparam int unsigned TableLimit = 65535;
  localparam int unsigned IdlePct    = 16;
  localparam int unsigned CalmFrom   = 40;
  localparam int unsigned CalmTo     = 64;
  localparam int unsigned RandWords  = 100;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [31:0] number;
    logic        is_prime;
  } verdict_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [31:0] candidate = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        is_prime;

  bit          odd_prime_mark [MarkDepth];
  logic [31:0] candidates_pending [$];
  verdict_t    verdicts_due [$];
  verdict_t    verdict_head;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches    = 0;

  prime_test_32bit_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .candidate_i (candidate),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .is_prime_o  (is_prime)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Table lookup, else trial division by marked odd primes p with p*p <= n.
  function automatic logic primality(input logic [31:0] n);
    int unsigned k;
    logic [63:0] p;
    if (n < 32'd3 || !n[0]) begin
      return n == 32'd2;
    end
    if (n <= TableLimit) begin
      return odd_prime_mark[n >> 1];
    end
    k = 1;
    p = 64'd3;
    while (k < MarkDepth && p * p <= {32'd0, n}) begin
      if (odd_prime_mark[k] && ({32'd0, n} % p) == 64'd0) begin
        return 1'b0;
      end
      k++;
      p += 64'd2;
    end
    return 1'b1;
  endfunction

  // Driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      candidate <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        verdicts_due.push_back('{number: candidate, is_prime: primality(candidate)});
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (candidates_pending.size() != 0 &&
            !((words_sent < CalmFrom || words_sent >= CalmTo) &&
              $urandom_range(0, 99) < IdlePct)) begin
          in_valid  <= 1'b1;
          candidate <= candidates_pending.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_checked++;
        if (verdicts_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports) begin
            $display("unexpected word: is_prime %0b", is_prime);
          end
        end else begin
          verdict_head = verdicts_due.pop_front();
          if (verdict_head.is_prime !== is_prime) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
              $display("mismatch: candidate %0d expected %0b got %0b",
                       verdict_head.number, verdict_head.is_prime, is_prime);
            end
          end
        end
      end
      out_stall <= (words_checked < CalmFrom || words_checked >= CalmTo) &&
                   ($urandom_range(0, 99) < IdlePct);
    end
  end

  initial begin : stimulus
    int unsigned p;
    int unsigned m;
    int unsigned k;
    int unsigned j;
    int unsigned i;
    int unsigned pick;
    logic [31:0] n;

    for (k = 0; k < MarkDepth; k++) begin
      odd_prime_mark[k] = 1'b1;
    end
    odd_prime_mark[0] = 1'b0;
    for (p = 3; p * p <= TableLimit; p += 2) begin
      if (odd_prime_mark[p >> 1]) begin
        for (m = p * p; m <= TableLimit; m += 2 * p) begin
          odd_prime_mark[m >> 1] = 1'b0;
        end
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero, one, two, small odds, table edges, square of a prime above the table,
    // large even, largest 32-bit prime, square of the largest table prime
    candidates_pending.push_back(32'd0);
    candidates_pending.push_back(32'd1);
    candidates_pending.push_back(32'd2);
    candidates_pending.push_back(32'd3);
    candidates_pending.push_back(32'd4);
    candidates_pending.push_back(32'd5);
    candidates_pending.push_back(32'd9);
    candidates_pending.push_back(32'd15);
    candidates_pending.push_back(32'd65521);
    candidates_pending.push_back(32'd65535);
    candidates_pending.push_back(32'd65537);
    candidates_pending.push_back(32'd65541);
    candidates_pending.push_back(32'd66049);
    candidates_pending.push_back(32'd2147483648);
    candidates_pending.push_back(32'd2147483649);
    candidates_pending.push_back(32'd4294967291);
    candidates_pending.push_back(32'd4293001441);
    candidates_pending.push_back(32'd4294967294);
    candidates_pending.push_back(32'd4294967295);

    // sender holds off until every verdict is back
    while (candidates_pending.size() != 0 || in_valid || verdicts_due.size() != 0) begin
      @(negedge clk);
    end

    for (i = 0; i < RandWords; i++) begin
      pick = $urandom_range(0, 15);
      if (i % 16 == 0) begin
        n = $urandom;
      end else if (pick < 2) begin
        n = $urandom & 32'hFFFF_FFFE;
      end else if (pick < 8) begin
        n = $urandom_range(0, TableLimit);
      end else if (pick < 13) begin
        n = $urandom_range(TableLimit + 1, 32'h0010_0000) | 32'd1;
      end else begin
        k = $urandom_range(128, 511);
        while (!odd_prime_mark[k]) k++;
        j = k;
        if (pick == 15) begin
          j = $urandom_range(128, 511);
          while (!odd_prime_mark[j]) j++;
        end
        n = (2 * k + 1) * (2 * j + 1);
      end
      candidates_pending.push_back(n);
    end

    while (candidates_pending.size() != 0 || in_valid || verdicts_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (50) @(negedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
